// ===== rtl/lfps_pkg.sv =====
`timescale 1ns / 1ps

package lfps_pkg;

    // Width of every configuration register and of the write data bus.
    localparam int CFG_W = 32;
    // Width of start and minimum values: rounding a value below 2^32 + 2^20
    // up to a page of at most 2^20 bytes stays below 2^33.
    localparam int CALC_W = 33;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_MODULE_SIZE    = 2'd0;
    localparam cfg_index_t CFG_LOWEST_ADDRESS = 2'd1;
    localparam cfg_index_t CFG_ADDRESS_LIMIT  = 2'd2;

    localparam logic [CFG_W-1:0] LIMIT_RESET    = 32'hC000_0000;
    localparam logic [31:0]      KIND_AVAILABLE = 32'd1;

    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NO_FIT    = 2'd1,
        STATUS_TOO_LARGE = 2'd2
    } lfps_status_t;

    // Settings derived from the configuration registers, held ready for the
    // per-entry evaluation.
    typedef struct packed {
        logic [CFG_W-1:0]  rounded_size;
        logic              too_large;
        logic [CALC_W-1:0] minimum;
        logic [CFG_W-1:0]  limit;
    } lfps_cfg_t;

    // Add-and-mask round up; the caller truncates to the address width.
    function automatic logic [63:0] lfps_round(input logic [63:0] v,
                                              input logic [63:0] pm1);
        return (v + pm1) & ~pm1;
    endfunction

endpackage

// ===== rtl/lfps_entry_if.sv =====
`timescale 1ns / 1ps

interface lfps_entry_if;
    logic        valid;
    logic        ready;
    logic [63:0] entry_address;
    logic [63:0] entry_length;
    logic [31:0] entry_kind;
    logic        last_entry;

    modport source (
        output valid,
        output entry_address,
        output entry_length,
        output entry_kind,
        output last_entry,
        input  ready
    );

    modport sink (
        input  valid,
        input  entry_address,
        input  entry_length,
        input  entry_kind,
        input  last_entry,
        output ready
    );
endinterface

// ===== rtl/lfps_result_if.sv =====
`timescale 1ns / 1ps

interface lfps_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] destination;
    logic [1:0]  status;

    modport source (
        output valid,
        output destination,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  destination,
        input  status,
        output ready
    );
endinterface

// ===== rtl/lfps_cfg.sv =====
`timescale 1ns / 1ps

module lfps_cfg #(
    parameter int PAGE_SIZE    = 4096,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  lfps_pkg::cfg_index_t            cfg_index,
    input  logic [lfps_pkg::CFG_W-1:0]      cfg_data,
    output lfps_pkg::lfps_cfg_t             cfg
);
    import lfps_pkg::*;

    localparam logic [63:0] PageMask = 64'(PAGE_SIZE - 1);
    localparam logic [63:0] AddrMask = {64{1'b1}} >> (64 - ADDRESS_BITS);
    localparam logic [CFG_W-1:0] SizeMax = CFG_W'(64'hFFFF_FFFF - PageMask);
    localparam logic [CALC_W-1:0] MinReset =
        CALC_W'(lfps_round(64'd1, PageMask) & AddrMask);

    lfps_cfg_t        cfg_reg;
    logic [63:0]      min_base;
    logic [CALC_W-1:0] min_new;
    logic [CFG_W-1:0] size_new;

    // Fold the rounding into the write so the datapath sees final values.
    always_comb
    begin
        min_base = ({32'd0, cfg_data} + 64'd1) & AddrMask;
        min_new  = CALC_W'(lfps_round(min_base, PageMask) & AddrMask);
        size_new = CFG_W'(lfps_round({32'd0, cfg_data}, PageMask));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rounded_size <= '0;
            cfg_reg.too_large    <= 1'b0;
            cfg_reg.minimum      <= MinReset;
            cfg_reg.limit        <= LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MODULE_SIZE:
                begin
                    cfg_reg.rounded_size <= size_new;
                    cfg_reg.too_large    <= (cfg_data > SizeMax);
                end
                CFG_LOWEST_ADDRESS:
                begin
                    cfg_reg.minimum <= min_new;
                end
                CFG_ADDRESS_LIMIT:
                begin
                    cfg_reg.limit <= cfg_data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lowest_fit_placement_search_unit.sv =====
`timescale 1ns / 1ps

// Channel   Role   Beat payload                                            
// --------  -----  ------------------------------------------------------- 
// entry     sink   entry_address, entry_length, entry_kind, last_entry     
// result    source destination, status (one beat per last entry)          
// cfg_*     write  cfg_write_en, cfg_index, cfg_data (no read-back)        
//
// One entry beat is taken every cycle unless a last entry waits on a stalled
// result; fit check, running minimum and result formation sit in one stage
// between entry and result registers; a result loads as its last entry retires.
// Reset clears the running best, both valid flags and the configuration registers.
// A stalled result only holds back a last entry; other entries keep flowing.

module lowest_fit_placement_search_unit #(
    parameter int PAGE_SIZE    = 4096,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    lfps_entry_if.sink                  entry,
    lfps_result_if.source               result,
    input  logic                        cfg_write_en,
    input  lfps_pkg::cfg_index_t        cfg_index,
    input  logic [lfps_pkg::CFG_W-1:0]  cfg_data
);
    import lfps_pkg::*;

    localparam logic [63:0] PageMask = 64'(PAGE_SIZE - 1);
    localparam logic [63:0] AddrMask = {64{1'b1}} >> (64 - ADDRESS_BITS);

    lfps_cfg_t cfg;

    // Entry register.
    logic        stg_valid_reg;
    logic [63:0] stg_addr_reg;
    logic [63:0] stg_len_reg;
    logic [31:0] stg_kind_reg;
    logic        stg_last_reg;

    // Running best and result register.
    logic [31:0]  best_reg;
    logic [31:0]  best_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [31:0]  out_dest_reg;
    logic [31:0]  out_dest_next;
    lfps_status_t out_status_reg;
    lfps_status_t out_status_next;

    logic              retire;
    logic              usable;
    logic [64:0]       end_sum;
    logic [31:0]       end_addr;
    logic [CALC_W-1:0] start_raw;
    logic [CALC_W-1:0] start;
    logic [CALC_W-1:0] room;
    logic              fits;
    logic              take;
    logic [31:0]       best_upd;

    lfps_cfg #(
        .PAGE_SIZE    (PAGE_SIZE),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // Retire the held entry unless it is a last entry facing a full result
    // register that is not being drained this cycle.
    assign retire      = stg_valid_reg && (!stg_last_reg || !out_valid_reg || result.ready);
    assign entry.ready = !stg_valid_reg || retire;

    always_comb
    begin
        // Entry counts only if available and starting below the limit.
        usable = (stg_kind_reg == KIND_AVAILABLE) && (stg_addr_reg[63:32] == 32'd0)
                 && (stg_addr_reg[31:0] < cfg.limit);

        // Saturate the 64-bit end, then clamp to the limit.
        end_sum  = {1'b0, stg_addr_reg} + {1'b0, stg_len_reg};
        end_addr = (end_sum[64] || (end_sum[63:0] > {32'd0, cfg.limit}))
                   ? cfg.limit : end_sum[31:0];

        start_raw = ({1'b0, stg_addr_reg[31:0]} < cfg.minimum)
                    ? cfg.minimum : {1'b0, stg_addr_reg[31:0]};
        start     = CALC_W'(lfps_round(64'(start_raw), PageMask) & AddrMask);
        room      = {1'b0, end_addr} - start;
        fits      = (start <= {1'b0, end_addr}) && ({1'b0, cfg.rounded_size} <= room);

        take     = usable && fits
                   && ((best_reg == 32'd0) || (start[31:0] < best_reg));
        best_upd = take ? start[31:0] : best_reg;

        best_next = best_reg;
        if (retire)
        begin
            best_next = stg_last_reg ? 32'd0 : best_upd;
        end

        if (cfg.too_large)
        begin
            out_dest_next   = 32'd0;
            out_status_next = STATUS_TOO_LARGE;
        end
        else if (best_upd == 32'd0)
        begin
            out_dest_next   = 32'd0;
            out_status_next = STATUS_NO_FIT;
        end
        else
        begin
            out_dest_next   = best_upd;
            out_status_next = STATUS_FOUND;
        end

        // Load on a retiring last entry, drop once the beat is taken.
        if (retire && stg_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (entry.ready)
            begin
                stg_valid_reg <= entry.valid;
            end
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (entry.valid && entry.ready)
        begin
            stg_addr_reg <= entry.entry_address;
            stg_len_reg  <= entry.entry_length;
            stg_kind_reg <= entry.entry_kind;
            stg_last_reg <= entry.last_entry;
        end
        if (retire && stg_last_reg)
        begin
            out_dest_reg   <= out_dest_next;
            out_status_reg <= out_status_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.destination = out_dest_reg;
    assign result.status      = out_status_reg;

`ifndef SYNTHESIS
    a_best_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        retire && stg_last_reg |=> best_reg == 32'd0)
        else $error("running best not cleared after last entry");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(retire && stg_last_reg))
        else $error("result beat without a retired last entry");

    a_found_iff_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_status_reg == STATUS_FOUND) == (out_dest_reg != 32'd0)))
        else $error("status and destination disagree");

    a_plain_entry_flows: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg && !stg_last_reg |-> entry.ready)
        else $error("non-last entry stalled the input");
`endif

endmodule

// ===== tb/tb_lowest_fit_placement_search_unit.sv =====
`timescale 1ns / 1ps

// Checks the lowest-fit placement search against a cycle-free model of the
// same search. Entry beats and register writes feed the model, and each
// result beat is popped against the oldest predicted placement.
module tb_lowest_fit_placement_search_unit;

    import lfps_pkg::*;

    localparam int          PAGE_SIZE    = 4096;
    localparam int          ADDRESS_BITS = 32;
    localparam logic [63:0] PAGE_BYTES   = 64'(PAGE_SIZE);
    localparam logic [63:0] ADDR_MASK    = {64{1'b1}} >> (64 - ADDRESS_BITS);
    localparam logic [63:0] WORD_MASK    = 64'hFFFF_FFFF;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          PHASES       = 8;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          CYCLE_LIMIT  = 200000;

    // Index 3 is decoded by nothing; writes to it must leave the search alone.
    localparam cfg_index_t CFG_SPARE_INDEX = 2'd3;

    typedef struct {
        logic [31:0]  destination;
        lfps_status_t status;
    } placement_t;

    // Running-minimum model of the search plus the queue of placements that
    // the block still owes.
    class placement_scoreboard;
        logic [31:0] size_reg;
        logic [31:0] lowest_reg;
        logic [31:0] limit_reg;
        logic [31:0] best_start;
        placement_t  placement_q[$];
        int          errors;
        int          entries;
        int          maps;
        int          found_cnt;
        int          no_fit_cnt;
        int          too_large_cnt;

        function new();
            size_reg      = '0;
            lowest_reg    = '0;
            limit_reg     = LIMIT_RESET;
            best_start    = '0;
            errors        = 0;
            entries       = 0;
            maps          = 0;
            found_cnt     = 0;
            no_fit_cnt    = 0;
            too_large_cnt = 0;
        endfunction

        function logic [63:0] page_round(logic [63:0] v);
            return ((v + PAGE_BYTES - 64'd1) & ~(PAGE_BYTES - 64'd1)) & ADDR_MASK;
        endfunction

        function logic [63:0] aligned_minimum();
            return page_round(({32'b0, lowest_reg} + 64'd1) & ADDR_MASK);
        endfunction

        function logic [63:0] rounded_size();
            return page_round({32'b0, size_reg}) & WORD_MASK;
        endfunction

        function void write_register(cfg_index_t idx, logic [31:0] v);
            case (idx)
                CFG_MODULE_SIZE:    size_reg   = v;
                CFG_LOWEST_ADDRESS: lowest_reg = v;
                CFG_ADDRESS_LIMIT:  limit_reg  = v;
                default: ;
            endcase
        endfunction

        function void note_entry(logic [63:0] addr, logic [63:0] len,
                                 logic [31:0] kind, logic last);
            logic [63:0] limit;
            logic [63:0] span_end;
            logic [63:0] start;
            logic [63:0] min_start;
            logic        too_large;
            placement_t  exp;
            entries++;
            limit     = {32'b0, limit_reg};
            min_start = aligned_minimum();
            too_large = {32'b0, size_reg} > (WORD_MASK - (PAGE_BYTES - 64'd1));
            if (kind == KIND_AVAILABLE && addr < limit) begin
                span_end = addr + len;
                if (span_end < addr)
                    span_end = '1;
                if (span_end > limit)
                    span_end = limit;
                start = (addr < min_start) ? min_start : addr;
                start = page_round(start & ADDR_MASK);
                if (start <= span_end && rounded_size() <= span_end - start) begin
                    if (best_start == 0 || start < {32'b0, best_start})
                        best_start = start[31:0];
                end
            end
            if (last) begin
                if (too_large) begin
                    exp.destination = '0;
                    exp.status      = STATUS_TOO_LARGE;
                end
                else if (best_start == 0) begin
                    exp.destination = '0;
                    exp.status      = STATUS_NO_FIT;
                end
                else begin
                    exp.destination = best_start;
                    exp.status      = STATUS_FOUND;
                end
                placement_q.push_back(exp);
                best_start = '0;
                maps++;
            end
        endfunction

        function void check_result(logic [31:0] destination, logic [1:0] status);
            placement_t exp;
            if (placement_q.size() == 0) begin
                $error("result beat with no placement pending: destination %h status %0d",
                       destination, status);
                errors++;
                return;
            end
            exp = placement_q.pop_front();
            case (exp.status)
                STATUS_FOUND:  found_cnt++;
                STATUS_NO_FIT: no_fit_cnt++;
                default:       too_large_cnt++;
            endcase
            if (destination !== exp.destination) begin
                $error("destination: expected %h, got %h", exp.destination, destination);
                errors++;
            end
            if (status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, status);
                errors++;
            end
        endfunction

        function int pending();
            return placement_q.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    cfg_index_t          cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    int                  send_idle_pct;
    int                  stall_pct;
    int                  cycle_count = 0;
    placement_scoreboard sb;

    lfps_entry_if  entry_ch();
    lfps_result_if result_ch();

    lowest_fit_placement_search_unit #(
        .PAGE_SIZE    (PAGE_SIZE),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry        (entry_ch.sink),
        .result       (result_ch.source),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop: the slowest legal run is far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stall the result channel at random, one decision per cycle, changing
    // only on the falling edge.
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Sample result beats on the rising edge, before the block updates.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.destination, result_ch.status);
    end

    // Offer one entry beat, idling first as the current phase asks, and hold
    // it until the block takes it. Enter and leave on a falling edge.
    task automatic send_entry(input logic [63:0] addr, input logic [63:0] len,
                              input logic [31:0] kind, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            entry_ch.valid <= 1'b0;
            @(negedge clk);
        end
        entry_ch.valid         <= 1'b1;
        entry_ch.entry_address <= addr;
        entry_ch.entry_length  <= len;
        entry_ch.entry_kind    <= kind;
        entry_ch.last_entry    <= last;
        @(posedge clk);
        while (!entry_ch.ready)
            @(posedge clk);
        sb.note_entry(addr, len, kind, last);
        @(negedge clk);
    endtask

    // Drop valid and wait until every placement owed has come back, then let
    // the pipeline settle so a trailing non-last entry cannot see new settings.
    task automatic drain_block();
        entry_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write all three registers plus the undecoded index, only while idle.
    task automatic apply_config(input logic [31:0] size, input logic [31:0] lowest,
                                input logic [31:0] limit);
        cfg_index_t  order [4];
        logic [31:0] vals  [4];
        order = '{CFG_MODULE_SIZE, CFG_LOWEST_ADDRESS, CFG_ADDRESS_LIMIT, CFG_SPARE_INDEX};
        vals  = '{size, lowest, limit, $urandom};
        drain_block();
        for (int i = 0; i < 4; i++) begin
            cfg_write_en <= 1'b1;
            cfg_index    <= order[i];
            cfg_data     <= vals[i];
            @(posedge clk);
            sb.write_register(order[i], vals[i]);
            @(negedge clk);
        end
        cfg_write_en <= 1'b0;
    endtask

    // Build one entry aimed at the current settings: addresses around the
    // minimum and the limit, lengths that just fit or just miss, and a share
    // of raw 64-bit noise so every bit toggles.
    task automatic make_entry(output logic [63:0] addr, output logic [63:0] len,
                              output logic [31:0] kind);
        logic [63:0] limit;
        logic [63:0] start;
        int          pick;
        limit = {32'b0, sb.limit_reg};
        pick  = $urandom_range(99);
        if (pick < 15)
            addr = {$urandom, $urandom};
        else if (pick < 25)
            addr = limit - 64'($urandom_range(16'h3000, 0));
        else if (pick < 40)
            addr = {32'b0, sb.lowest_reg + 32'($urandom_range(16'h2000, 0))};
        else begin
            addr = (limit == 0) ? {32'b0, $urandom}
                                : {32'b0, 32'($urandom_range(sb.limit_reg - 1, 0))};
            if ($urandom_range(1))
                addr = addr & ~(PAGE_BYTES - 64'd1);
        end

        pick = $urandom_range(99);
        if (pick < 40) begin
            start = (addr < sb.aligned_minimum()) ? sb.aligned_minimum() : addr;
            start = sb.page_round(start & ADDR_MASK);
            len   = start - addr + sb.rounded_size()
                  + 64'($urandom_range(16'h2000, 0)) - 64'h1000;
        end
        else if (pick < 55)
            len = {$urandom, $urandom};
        else if (pick < 80)
            len = {32'b0, $urandom};
        else
            len = 64'($urandom_range(16'h4000, 0));

        pick = $urandom_range(99);
        if (pick < 75)
            kind = KIND_AVAILABLE;
        else if (pick < 85)
            kind = 32'd0;
        else if (pick < 90)
            kind = 32'd2;
        else
            kind = $urandom;
    endtask

    // Send maps of random length until the item budget is spent. Most are
    // well-formed, some are long, a few are pure noise.
    task automatic run_random_maps(input int budget);
        logic [63:0] addr;
        logic [63:0] len;
        logic [31:0] kind;
        int          sent;
        int          map_len;
        sent = 0;
        while (sent < budget) begin
            map_len = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
            for (int j = 0; j < map_len; j++) begin
                make_entry(addr, len, kind);
                if ($urandom_range(19) == 0) begin
                    addr = {$urandom, $urandom};
                    len  = {$urandom, $urandom};
                    kind = $urandom;
                end
                send_entry(addr, len, kind, j == map_len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb                     = new();
        rst_n                  = 1'b0;
        cfg_write_en           = 1'b0;
        cfg_index              = CFG_MODULE_SIZE;
        cfg_data               = '0;
        entry_ch.valid         = 1'b0;
        entry_ch.entry_address = '0;
        entry_ch.entry_length  = '0;
        entry_ch.entry_kind    = '0;
        entry_ch.last_entry    = 1'b0;
        result_ch.ready        = 1'b0;
        send_idle_pct          = 0;
        stall_pct              = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed maps. Minimum is 0x1000, size two pages.
        apply_config(32'h0000_2000, 32'h0000_0FFF, LIMIT_RESET);
        send_entry(64'h1000, 64'h10_0000, 32'd2, 1'b0);          // reserved kind
        send_entry(64'h2000, 64'h10_0000, 32'hFFFF_FFFF, 1'b0);  // top kind code
        send_entry(64'hC000_0000, 64'h10_0000, KIND_AVAILABLE, 1'b0); // at limit
        send_entry('1, '1, KIND_AVAILABLE, 1'b0);                // all ones
        send_entry(64'h0, 64'h3000, KIND_AVAILABLE, 1'b0);       // raised to minimum
        send_entry(64'h5000, 64'h1FFF, KIND_AVAILABLE, 1'b0);    // one byte short
        send_entry(64'h800, '1, KIND_AVAILABLE, 1'b1);           // end saturates
        send_entry(64'hBFFF_F000, 64'h1000_0000, KIND_AVAILABLE, 1'b1); // clamp, no fit
        send_entry(64'h0, 64'h0, 32'd0, 1'b1);                   // nothing usable
        send_entry(64'h1_0001, 64'h1_0000, KIND_AVAILABLE, 1'b0);
        send_entry(64'h3000, 64'h2000, KIND_AVAILABLE, 1'b1);    // lower start wins

        // Minimum of zero: a start at address zero counts as nothing found.
        apply_config(32'h0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_entry(64'h0, 64'h1000, KIND_AVAILABLE, 1'b0);
        send_entry(64'h5000, 64'h1000, KIND_AVAILABLE, 1'b1);    // replaces the zero
        send_entry(64'h7000, 64'h1000, KIND_AVAILABLE, 1'b0);
        send_entry(64'h0, 64'h2000, KIND_AVAILABLE, 1'b1);       // zero overrides
        send_entry(64'hFFFF_F001, 64'h10, KIND_AVAILABLE, 1'b1); // start wraps to zero

        // Size one byte past the largest roundable value.
        apply_config(32'hFFFF_F001, 32'h0, LIMIT_RESET);
        send_entry(64'h1000, 64'h1_0000, KIND_AVAILABLE, 1'b1);

        // Limit of zero skips everything; minimum wraps to zero.
        apply_config(32'h0, 32'hFFFF_F000, 32'h0);
        send_entry(64'h0, 64'h1000, KIND_AVAILABLE, 1'b1);

        // Random phases: each idling pattern twice, each with its own settings.
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 81; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            case (p)
                0: apply_config(32'h0, 32'h0, LIMIT_RESET);
                1: apply_config(32'h1000, 32'h0FFF, LIMIT_RESET);
                2: apply_config(32'hFFFF_F000, 32'h0, 32'hFFFF_FFFF);
                3: apply_config(32'hFFFF_F001, $urandom, $urandom);
                4: apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
                5: apply_config(32'($urandom_range(32'h8000, 0)), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                6: apply_config(32'($urandom_range(32'h1_0000, 0)), $urandom, $urandom);
                default: apply_config(32'h1, 32'hFFFF_F000, 32'hFFFF_FFFF);
            endcase
            run_random_maps(RANDOM_ITEMS / PHASES);
        end

        // Collect the last placements and give the pipeline time to misbehave.
        drain_block();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d placements never arrived", sb.pending());
            sb.errors++;
        end

        $display("Covered %0d entry beats in %0d maps across 12 register settings",
                 sb.entries, sb.maps);
        $display("Placements checked: %0d found, %0d without fit, %0d oversized",
                 sb.found_cnt, sb.no_fit_cnt, sb.too_large_cnt);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
